FILE: rtl/lcs_pkg.sv
// Shared types and constants of the literal and comment scanner.
package lcs_pkg;

    // Character class code produced by the front end.
    typedef logic [3:0] t_cls;

    localparam t_cls CL_OTHER = 4'd0;
    localparam t_cls CL_SPACE = 4'd1;
    localparam t_cls CL_NL    = 4'd2;
    localparam t_cls CL_SLASH = 4'd3;
    localparam t_cls CL_STAR  = 4'd4;
    localparam t_cls CL_AMP   = 4'd5;
    localparam t_cls CL_BAR   = 4'd6;
    localparam t_cls CL_DQ    = 4'd7;
    localparam t_cls CL_SQ    = 4'd8;
    localparam t_cls CL_BSL   = 4'd9;
    localparam t_cls CL_DOT   = 4'd10;
    localparam t_cls CL_DIGIT = 4'd11;
    localparam t_cls CL_EXP   = 4'd12;
    localparam t_cls CL_SIGN  = 4'd13;
    localparam t_cls CL_EOI   = 4'd14;

    // Token kind codes.
    typedef logic [2:0] t_kind;

    localparam t_kind K_INT   = 3'd0;
    localparam t_kind K_FLOAT = 3'd1;
    localparam t_kind K_STR   = 3'd2;
    localparam t_kind K_CHAR  = 3'd3;
    localparam t_kind K_AND   = 3'd4;
    localparam t_kind K_OR    = 3'd5;
    localparam t_kind K_BAD   = 3'd6;
    localparam t_kind K_OTHER = 3'd7;

    // Token length field width and its hard ceiling.
    localparam int LEN_W   = 12;
    localparam int LEN_MAX = 4095;

    // Depth of the queue between front and back.
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    // Head of the queue as seen by the back end.
    typedef struct packed {
        logic valid;
        t_cls cls;
    } t_qhead;

endpackage

FILE: rtl/lcs_front.sv
// Front end: classifies each incoming character into a class code.
module lcs_front (
    input  logic [7:0]  i_ch,
    input  logic        i_eoi,
    output lcs_pkg::t_cls o_cls
);

    // Map the byte to the class the scanner state machine acts on.
    always_comb begin
        if (i_eoi) begin
            o_cls = lcs_pkg::CL_EOI;
        end else if (i_ch >= 8'h30 && i_ch <= 8'h39) begin
            o_cls = lcs_pkg::CL_DIGIT;
        end else if (i_ch == 8'h0A) begin
            o_cls = lcs_pkg::CL_NL;
        end else if (i_ch == 8'h20 || (i_ch >= 8'h09 && i_ch <= 8'h0D)) begin
            o_cls = lcs_pkg::CL_SPACE;
        end else begin
            case (i_ch)
                8'h2F:        o_cls = lcs_pkg::CL_SLASH;
                8'h2A:        o_cls = lcs_pkg::CL_STAR;
                8'h26:        o_cls = lcs_pkg::CL_AMP;
                8'h7C:        o_cls = lcs_pkg::CL_BAR;
                8'h22:        o_cls = lcs_pkg::CL_DQ;
                8'h27:        o_cls = lcs_pkg::CL_SQ;
                8'h5C:        o_cls = lcs_pkg::CL_BSL;
                8'h2E:        o_cls = lcs_pkg::CL_DOT;
                8'h65, 8'h45: o_cls = lcs_pkg::CL_EXP;
                8'h2B, 8'h2D: o_cls = lcs_pkg::CL_SIGN;
                default:      o_cls = lcs_pkg::CL_OTHER;
            endcase
        end
    end

endmodule

FILE: rtl/lcs_queue.sv
// Short queue of classified items between the front and back ends.
module lcs_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lcs_pkg::t_cls   i_cls,
    output logic            o_full,
    input  logic            i_pop,
    output lcs_pkg::t_qhead o_head
);

    lcs_pkg::t_cls                 r_mem [lcs_pkg::Q_DEPTH];
    logic [lcs_pkg::Q_AW-1:0]      r_wptr, n_wptr;
    logic [lcs_pkg::Q_AW-1:0]      r_rptr, n_rptr;
    logic [lcs_pkg::Q_AW:0]        r_count, n_count;
    logic                          w_push;
    logic                          w_pop;

    // Guard the handshakes against full and empty.
    assign o_full = (r_count == (lcs_pkg::Q_AW+1)'(lcs_pkg::Q_DEPTH));
    assign w_push = i_push && !o_full;
    assign w_pop  = i_pop && (r_count != '0);

    assign o_head.valid = (r_count != '0);
    assign o_head.cls   = r_mem[r_rptr];

    // Pointer and fill count updates.
    always_comb begin
        n_wptr  = w_push ? r_wptr + 1'b1 : r_wptr;
        n_rptr  = w_pop ? r_rptr + 1'b1 : r_rptr;
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Storage for the queued class codes.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_cls;
        end
    end

endmodule

FILE: rtl/lcs_back.sv
// Back end: scanner state machine with length counter and result register.
module lcs_back #(
    parameter int LEN_CAP = 4095
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  lcs_pkg::t_qhead            i_head,
    output logic                       o_pop,
    output logic                       o_valid,
    input  logic                       i_ready,
    output lcs_pkg::t_kind             o_kind,
    output logic [lcs_pkg::LEN_W-1:0]  o_token_length,
    output logic                       o_length_saturated,
    output logic [1:0]                 o_replay_count
);

    localparam logic [lcs_pkg::LEN_W-1:0] CAP = lcs_pkg::LEN_W'(LEN_CAP);

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_SLASH    = 5'd1;
    localparam logic [4:0] S_LINE     = 5'd2;
    localparam logic [4:0] S_BLOCK    = 5'd3;
    localparam logic [4:0] S_AMP      = 5'd4;
    localparam logic [4:0] S_BAR      = 5'd5;
    localparam logic [4:0] S_STR      = 5'd6;
    localparam logic [4:0] S_STR_ESC  = 5'd7;
    localparam logic [4:0] S_CHR      = 5'd8;
    localparam logic [4:0] S_CHR_ESC  = 5'd9;
    localparam logic [4:0] S_LEAD_DOT = 5'd10;
    localparam logic [4:0] S_INT      = 5'd11;
    localparam logic [4:0] S_INT_DOT  = 5'd12;
    localparam logic [4:0] S_FRAC     = 5'd13;
    localparam logic [4:0] S_EXP      = 5'd14;
    localparam logic [4:0] S_EXP_SIGN = 5'd15;
    localparam logic [4:0] S_EXP_DIG  = 5'd16;

    logic [4:0]                r_mode, n_mode;
    logic [lcs_pkg::LEN_W-1:0] r_len, n_len;
    logic                      r_body, n_body;
    logic                      r_star, n_star;
    logic [lcs_pkg::LEN_W-1:0] w_len1, w_len2;
    lcs_pkg::t_cls             w_cls;
    logic                      w_eoi;

    logic                      e_fire;
    lcs_pkg::t_kind            e_kind;
    logic [lcs_pkg::LEN_W-1:0] e_len;
    logic [1:0]                e_rep;

    logic                      r_out_valid;
    lcs_pkg::t_kind            r_kind;
    logic [lcs_pkg::LEN_W-1:0] r_tlen;
    logic                      r_sat;
    logic [1:0]                r_rep;

    // Take one item whenever the result register is free or being drained.
    assign o_pop = i_head.valid && (!r_out_valid || i_ready);
    assign w_cls = i_head.cls;
    assign w_eoi = (w_cls == lcs_pkg::CL_EOI);

    // Saturating length after one and after two more characters.
    assign w_len1 = (r_len < CAP) ? r_len + 1'b1 : r_len;
    assign w_len2 = (w_len1 < CAP) ? w_len1 + 1'b1 : w_len1;

    // Next state and result of the current item.
    always_comb begin
        n_mode = r_mode;
        n_len  = r_len;
        n_body = r_body;
        n_star = r_star;
        e_fire = 1'b0;
        e_kind = lcs_pkg::K_OTHER;
        e_len  = '0;
        e_rep  = 2'd0;
        unique case (r_mode)
            S_IDLE: begin
                if (w_eoi || w_cls == lcs_pkg::CL_SPACE || w_cls == lcs_pkg::CL_NL) begin
                    n_mode = S_IDLE;
                end else if (w_cls == lcs_pkg::CL_SLASH) begin
                    n_mode = S_SLASH;
                end else if (w_cls == lcs_pkg::CL_AMP) begin
                    n_mode = S_AMP;
                end else if (w_cls == lcs_pkg::CL_BAR) begin
                    n_mode = S_BAR;
                end else begin
                    n_len = lcs_pkg::LEN_W'(1);
                    if (w_cls == lcs_pkg::CL_DQ) begin
                        n_mode = S_STR;
                    end else if (w_cls == lcs_pkg::CL_SQ) begin
                        n_mode = S_CHR;
                        n_body = 1'b0;
                    end else if (w_cls == lcs_pkg::CL_DOT) begin
                        n_mode = S_LEAD_DOT;
                    end else if (w_cls == lcs_pkg::CL_DIGIT) begin
                        n_mode = S_INT;
                    end else begin
                        e_fire = 1'b1;
                        e_rep  = 2'd1;
                    end
                end
            end
            S_SLASH: begin
                if (w_eoi) begin
                    e_fire = 1'b1;
                    e_rep  = 2'd1;
                end else if (w_cls == lcs_pkg::CL_SLASH) begin
                    n_mode = S_LINE;
                end else if (w_cls == lcs_pkg::CL_STAR) begin
                    n_mode = S_BLOCK;
                    n_star = 1'b0;
                end else begin
                    e_fire = 1'b1;
                    e_rep  = 2'd2;
                end
            end
            S_LINE: begin
                if (w_eoi || w_cls == lcs_pkg::CL_NL) begin
                    n_mode = S_IDLE;
                    n_len  = '0;
                    n_body = 1'b0;
                    n_star = 1'b0;
                end
            end
            S_BLOCK: begin
                if (w_eoi) begin
                    e_fire = 1'b1;
                    e_kind = lcs_pkg::K_BAD;
                end else if (r_star && w_cls == lcs_pkg::CL_SLASH) begin
                    n_mode = S_IDLE;
                    n_len  = '0;
                    n_body = 1'b0;
                    n_star = 1'b0;
                end else begin
                    n_star = (w_cls == lcs_pkg::CL_STAR);
                end
            end
            S_AMP, S_BAR: begin
                e_fire = 1'b1;
                if (w_eoi) begin
                    e_rep = 2'd1;
                end else if ((r_mode == S_AMP && w_cls == lcs_pkg::CL_AMP) ||
                             (r_mode == S_BAR && w_cls == lcs_pkg::CL_BAR)) begin
                    e_kind = (r_mode == S_AMP) ? lcs_pkg::K_AND : lcs_pkg::K_OR;
                    e_len  = lcs_pkg::LEN_W'(2);
                end else begin
                    e_rep = 2'd2;
                end
            end
            S_STR, S_CHR: begin
                if (w_eoi) begin
                    e_fire = 1'b1;
                    e_kind = lcs_pkg::K_BAD;
                    e_len  = r_len;
                end else begin
                    n_len = w_len1;
                    if (w_cls == lcs_pkg::CL_BSL) begin
                        n_mode = (r_mode == S_STR) ? S_STR_ESC : S_CHR_ESC;
                        n_body = 1'b1;
                    end else if (r_mode == S_STR && w_cls == lcs_pkg::CL_DQ) begin
                        e_fire = 1'b1;
                        e_kind = lcs_pkg::K_STR;
                        e_len  = w_len1;
                    end else if (r_mode == S_CHR && w_cls == lcs_pkg::CL_SQ) begin
                        // An empty char literal is malformed.
                        e_fire = 1'b1;
                        e_kind = r_body ? lcs_pkg::K_CHAR : lcs_pkg::K_BAD;
                        e_len  = w_len1;
                    end else begin
                        n_body = 1'b1;
                    end
                end
            end
            S_STR_ESC, S_CHR_ESC: begin
                if (w_eoi) begin
                    e_fire = 1'b1;
                    e_kind = lcs_pkg::K_BAD;
                    e_len  = r_len;
                end else begin
                    n_len  = w_len1;
                    n_mode = (r_mode == S_STR_ESC) ? S_STR : S_CHR;
                end
            end
            S_LEAD_DOT: begin
                if (w_eoi) begin
                    e_fire = 1'b1;
                    e_rep  = 2'd1;
                end else if (w_cls == lcs_pkg::CL_DIGIT) begin
                    n_len  = w_len1;
                    n_mode = S_FRAC;
                end else begin
                    e_fire = 1'b1;
                    e_rep  = 2'd2;
                end
            end
            S_INT: begin
                if (w_eoi) begin
                    e_fire = 1'b1;
                    e_kind = lcs_pkg::K_INT;
                    e_len  = r_len;
                end else if (w_cls == lcs_pkg::CL_DIGIT) begin
                    n_len = w_len1;
                end else if (w_cls == lcs_pkg::CL_DOT) begin
                    n_mode = S_INT_DOT;
                end else if (w_cls == lcs_pkg::CL_EXP) begin
                    n_len  = w_len1;
                    n_mode = S_EXP;
                end else begin
                    e_fire = 1'b1;
                    e_kind = lcs_pkg::K_INT;
                    e_len  = r_len;
                    e_rep  = 2'd1;
                end
            end
            S_INT_DOT: begin
                // A second dot leaves the integer and hands back the range operator.
                if (w_cls == lcs_pkg::CL_DOT) begin
                    e_fire = 1'b1;
                    e_kind = lcs_pkg::K_INT;
                    e_len  = r_len;
                    e_rep  = 2'd2;
                end else if (w_eoi) begin
                    e_fire = 1'b1;
                    e_kind = lcs_pkg::K_FLOAT;
                    e_len  = w_len1;
                end else if (w_cls == lcs_pkg::CL_DIGIT) begin
                    n_len  = w_len2;
                    n_mode = S_FRAC;
                end else if (w_cls == lcs_pkg::CL_EXP) begin
                    n_len  = w_len2;
                    n_mode = S_EXP;
                end else begin
                    e_fire = 1'b1;
                    e_kind = lcs_pkg::K_FLOAT;
                    e_len  = w_len1;
                    e_rep  = 2'd1;
                end
            end
            S_FRAC, S_EXP_DIG: begin
                if (w_eoi) begin
                    e_fire = 1'b1;
                    e_kind = lcs_pkg::K_FLOAT;
                    e_len  = r_len;
                end else if (w_cls == lcs_pkg::CL_DIGIT) begin
                    n_len = w_len1;
                end else if (r_mode == S_FRAC && w_cls == lcs_pkg::CL_EXP) begin
                    n_len  = w_len1;
                    n_mode = S_EXP;
                end else begin
                    e_fire = 1'b1;
                    e_kind = lcs_pkg::K_FLOAT;
                    e_len  = r_len;
                    e_rep  = 2'd1;
                end
            end
            S_EXP, S_EXP_SIGN: begin
                if (w_eoi) begin
                    e_fire = 1'b1;
                    e_kind = lcs_pkg::K_BAD;
                    e_len  = r_len;
                end else if (r_mode == S_EXP && w_cls == lcs_pkg::CL_SIGN) begin
                    n_len  = w_len1;
                    n_mode = S_EXP_SIGN;
                end else if (w_cls == lcs_pkg::CL_DIGIT) begin
                    n_len  = w_len1;
                    n_mode = S_EXP_DIG;
                end else begin
                    e_fire = 1'b1;
                    e_kind = lcs_pkg::K_BAD;
                    e_len  = r_len;
                    e_rep  = 2'd1;
                end
            end
            default: begin
                n_mode = S_IDLE;
                n_len  = '0;
                n_body = 1'b0;
                n_star = 1'b0;
            end
        endcase
        // Every result returns the scanner to its reset state.
        if (e_fire) begin
            n_mode = S_IDLE;
            n_len  = '0;
            n_body = 1'b0;
            n_star = 1'b0;
        end
    end

    // Scanner state registers advance only on a taken item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= S_IDLE;
            r_len  <= '0;
            r_body <= 1'b0;
            r_star <= 1'b0;
        end else if (o_pop) begin
            r_mode <= n_mode;
            r_len  <= n_len;
            r_body <= n_body;
            r_star <= n_star;
        end
    end

    // Result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= e_fire;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (o_pop && e_fire) begin
            r_kind <= e_kind;
            r_tlen <= e_len;
            r_sat  <= (e_len >= CAP);
            r_rep  <= e_rep;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_kind             = r_kind;
    assign o_token_length     = r_tlen;
    assign o_length_saturated = r_sat;
    assign o_replay_count     = r_rep;

endmodule

FILE: rtl/literal_and_comment_scanner.sv
// The item that completes a token passes through the queue and then the result register
// before its result can be taken.
// Throughput: one character per cycle while the result register is free or being drained,
// set by the back-end state machine taking one queued item per cycle; a four-entry queue
// absorbs output stalls. Reset (synchronous, active low) empties the queue, returns the
// scanner to idle and drops any pending result.
// Top level of the literal and comment scanner.
module literal_and_comment_scanner #(
    parameter int MAX_TOKEN_LEN = 4095
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_ch,
    input  logic        i_end_of_input,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_kind,
    output logic [11:0] o_token_length,
    output logic        o_length_saturated,
    output logic [1:0]  o_replay_count
);

    localparam int LEN_CAP = (MAX_TOKEN_LEN < lcs_pkg::LEN_MAX) ?
                             MAX_TOKEN_LEN : lcs_pkg::LEN_MAX;

    lcs_pkg::t_cls   w_cls;
    lcs_pkg::t_qhead w_head;
    logic            w_full;
    logic            w_pop;

    // Front end classifies the incoming character.
    lcs_front u_front (
        .i_ch  (i_ch),
        .i_eoi (i_end_of_input),
        .o_cls (w_cls)
    );

    assign o_ready = !w_full;

    // Queue decouples the input side from the scanner.
    lcs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_valid),
        .i_cls   (w_cls),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_head  (w_head)
    );

    // Back end runs the scanner and holds the result.
    lcs_back #(
        .LEN_CAP (LEN_CAP)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_head             (w_head),
        .o_pop              (w_pop),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_kind             (o_kind),
        .o_token_length     (o_token_length),
        .o_length_saturated (o_length_saturated),
        .o_replay_count     (o_replay_count)
    );

endmodule

FILE: rtl/lcs_checker.sv
// Port-level checker for the literal and comment scanner, with its bind.
module lcs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [2:0]  o_kind,
    input logic [11:0] o_token_length,
    input logic        o_length_saturated,
    input logic [1:0]  o_replay_count
);

    // A stalled result holds its kind and length.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_kind) && $stable(o_token_length))
        else $error("stalled result changed");

    // Unhandled characters carry no length.
    a_other: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == lcs_pkg::K_OTHER |->
            o_token_length == 12'd0 && !o_length_saturated && o_replay_count != 2'd0)
        else $error("unhandled result has length or no replay");

    // The two-character operators are complete tokens.
    a_oper: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == lcs_pkg::K_AND || o_kind == lcs_pkg::K_OR) |->
            o_token_length == 12'd2 && o_replay_count == 2'd0)
        else $error("operator result malformed");

    // Quoted literals consume their closing quote.
    a_quote: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == lcs_pkg::K_STR || o_kind == lcs_pkg::K_CHAR) |->
            o_replay_count == 2'd0 && o_token_length >= 12'd2)
        else $error("quoted literal result malformed");

    // Never more than two characters are handed back.
    a_replay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_replay_count != 2'd3)
        else $error("replay count out of range");

endmodule

bind literal_and_comment_scanner lcs_checker u_lcs_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .o_valid            (o_valid),
    .i_ready            (i_ready),
    .o_kind             (o_kind),
    .o_token_length     (o_token_length),
    .o_length_saturated (o_length_saturated),
    .o_replay_count     (o_replay_count)
);

FILE: verif/tb_literal_and_comment_scanner.sv
// Testbench for the literal and comment scanner: character streams against a token predictor.
module tb_literal_and_comment_scanner;

    localparam int MAX_TOKEN_LEN = 4095;
    localparam int LEN_CAP       = (MAX_TOKEN_LEN < lcs_pkg::LEN_MAX) ?
                                   MAX_TOKEN_LEN : lcs_pkg::LEN_MAX;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int REPORT_LIMIT  = 100;
    localparam int EXP_DEPTH     = 1024;
    localparam int LONG_LEN      = 40;

    // Characters the tests send, most of them treated specially by the scanner.
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_E_UP  = 8'h45;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_E_LO  = 8'h65;
    localparam logic [7:0] CH_BAR   = 8'h7C;
    localparam logic [7:0] CH_LOW_A = 8'h61;

    // Scan modes of the predictor.
    typedef enum logic [4:0] {
        SC_IDLE, SC_SLASH, SC_LINE, SC_BLOCK, SC_AMP, SC_BAR, SC_STR, SC_STR_ESC,
        SC_CHR, SC_CHR_ESC, SC_LEAD_DOT, SC_INT, SC_INT_DOT, SC_FRAC, SC_EXP,
        SC_EXP_SIGN, SC_EXP_DIG
    } t_scan_mode;

    typedef struct {
        lcs_pkg::t_kind kind;
        logic [11:0]    length;
        logic           saturated;
        logic [1:0]     replay;
    } t_token;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_ch = 8'h00;
    logic        i_end_of_input = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [2:0]  o_kind;
    logic [11:0] o_token_length;
    logic        o_length_saturated;
    logic [1:0]  o_replay_count;

    // Predictor state.
    t_scan_mode  scan_mode = SC_IDLE;
    logic [11:0] scan_len = 12'd0;
    logic        body_seen = 1'b0;
    logic        star_seen = 1'b0;

    // Ring of expected tokens; the counters only grow.
    t_token      exp_tokens[EXP_DEPTH];
    int          exp_head = 0;
    int          exp_tail = 0;
    int          mismatch_count = 0;
    int          bad_token_count = 0;
    int          sent_count = 0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    logic        hold_request = 1'b0;
    logic        rx_hold = 1'b0;

    literal_and_comment_scanner #(
        .MAX_TOKEN_LEN(MAX_TOKEN_LEN)
    ) u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_ch               (i_ch),
        .i_end_of_input     (i_end_of_input),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_kind             (o_kind),
        .o_token_length     (o_token_length),
        .o_length_saturated (o_length_saturated),
        .o_replay_count     (o_replay_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Number of predicted tokens not yet received.
    function automatic int pending_tokens();
        return exp_tail - exp_head;
    endfunction

    // Return the predictor to its idle state.
    task automatic clear_scan();
        scan_mode = SC_IDLE;
        scan_len  = 12'd0;
        body_seen = 1'b0;
        star_seen = 1'b0;
    endtask

    task automatic grow_len();
        if (scan_len < LEN_CAP) begin
            scan_len = scan_len + 12'd1;
        end
    endtask

    // Queue one expected token and end the current scan.
    task automatic emit_token(input lcs_pkg::t_kind kind, input logic [11:0] len,
                              input logic [1:0] replay);
        t_token tok;
        tok.kind      = kind;
        tok.length    = len;
        tok.saturated = (len >= LEN_CAP);
        tok.replay    = replay;
        exp_tokens[exp_tail % EXP_DEPTH] = tok;
        exp_tail++;
        clear_scan();
    endtask

    // Advance the predicted scanner by one accepted item.
    task automatic predict_token(input logic [7:0] c, input logic eoi);
        logic [11:0] held;
        logic        dig;
        logic        exp_letter;
        held       = scan_len;
        dig        = (c >= CH_ZERO) && (c <= CH_NINE);
        exp_letter = (c == CH_E_LO) || (c == CH_E_UP);
        case (scan_mode)
            SC_IDLE: begin
                if (eoi || c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
                end else if (c == CH_SLASH) begin
                    scan_mode = SC_SLASH;
                end else if (c == CH_AMP) begin
                    scan_mode = SC_AMP;
                end else if (c == CH_BAR) begin
                    scan_mode = SC_BAR;
                end else begin
                    scan_len = 12'd0;
                    grow_len();
                    if (c == CH_DQ) begin
                        scan_mode = SC_STR;
                    end else if (c == CH_SQ) begin
                        scan_mode = SC_CHR;
                        body_seen = 1'b0;
                    end else if (c == CH_DOT) begin
                        scan_mode = SC_LEAD_DOT;
                    end else if (dig) begin
                        scan_mode = SC_INT;
                    end else begin
                        emit_token(lcs_pkg::K_OTHER, 12'd0, 2'd1);
                    end
                end
            end
            SC_SLASH: begin
                if (eoi) begin
                    emit_token(lcs_pkg::K_OTHER, 12'd0, 2'd1);
                end else if (c == CH_SLASH) begin
                    scan_mode = SC_LINE;
                end else if (c == CH_STAR) begin
                    scan_mode = SC_BLOCK;
                    star_seen = 1'b0;
                end else begin
                    emit_token(lcs_pkg::K_OTHER, 12'd0, 2'd2);
                end
            end
            SC_LINE: begin
                if (eoi || c == CH_NL) begin
                    clear_scan();
                end
            end
            SC_BLOCK: begin
                if (eoi) begin
                    emit_token(lcs_pkg::K_BAD, 12'd0, 2'd0);
                end else if (star_seen && c == CH_SLASH) begin
                    clear_scan();
                end else begin
                    star_seen = (c == CH_STAR);
                end
            end
            SC_AMP, SC_BAR: begin
                if (eoi) begin
                    emit_token(lcs_pkg::K_OTHER, 12'd0, 2'd1);
                end else if (c == ((scan_mode == SC_AMP) ? CH_AMP : CH_BAR)) begin
                    emit_token((scan_mode == SC_AMP) ? lcs_pkg::K_AND : lcs_pkg::K_OR,
                               12'd2, 2'd0);
                end else begin
                    emit_token(lcs_pkg::K_OTHER, 12'd0, 2'd2);
                end
            end
            SC_STR, SC_CHR: begin
                if (eoi) begin
                    emit_token(lcs_pkg::K_BAD, held, 2'd0);
                end else begin
                    grow_len();
                    if (c == CH_BSL) begin
                        scan_mode = (scan_mode == SC_STR) ? SC_STR_ESC : SC_CHR_ESC;
                        body_seen = 1'b1;
                    end else if (scan_mode == SC_STR && c == CH_DQ) begin
                        emit_token(lcs_pkg::K_STR, scan_len, 2'd0);
                    end else if (scan_mode == SC_CHR && c == CH_SQ) begin
                        // An empty char literal is malformed.
                        emit_token(body_seen ? lcs_pkg::K_CHAR : lcs_pkg::K_BAD,
                                   scan_len, 2'd0);
                    end else begin
                        body_seen = 1'b1;
                    end
                end
            end
            SC_STR_ESC, SC_CHR_ESC: begin
                if (eoi) begin
                    emit_token(lcs_pkg::K_BAD, held, 2'd0);
                end else begin
                    grow_len();
                    scan_mode = (scan_mode == SC_STR_ESC) ? SC_STR : SC_CHR;
                end
            end
            SC_LEAD_DOT: begin
                if (eoi) begin
                    emit_token(lcs_pkg::K_OTHER, 12'd0, 2'd1);
                end else if (dig) begin
                    grow_len();
                    scan_mode = SC_FRAC;
                end else begin
                    emit_token(lcs_pkg::K_OTHER, 12'd0, 2'd2);
                end
            end
            SC_INT: begin
                if (eoi) begin
                    emit_token(lcs_pkg::K_INT, held, 2'd0);
                end else if (dig) begin
                    grow_len();
                end else if (c == CH_DOT) begin
                    scan_mode = SC_INT_DOT;
                end else if (exp_letter) begin
                    grow_len();
                    scan_mode = SC_EXP;
                end else begin
                    emit_token(lcs_pkg::K_INT, held, 2'd1);
                end
            end
            SC_INT_DOT: begin
                // A second dot leaves the range operator to the next token.
                if (c == CH_DOT && !eoi) begin
                    emit_token(lcs_pkg::K_INT, held, 2'd2);
                end else begin
                    grow_len();
                    if (eoi) begin
                        emit_token(lcs_pkg::K_FLOAT, scan_len, 2'd0);
                    end else if (dig) begin
                        grow_len();
                        scan_mode = SC_FRAC;
                    end else if (exp_letter) begin
                        grow_len();
                        scan_mode = SC_EXP;
                    end else begin
                        emit_token(lcs_pkg::K_FLOAT, scan_len, 2'd1);
                    end
                end
            end
            SC_FRAC: begin
                if (eoi) begin
                    emit_token(lcs_pkg::K_FLOAT, held, 2'd0);
                end else if (dig) begin
                    grow_len();
                end else if (exp_letter) begin
                    grow_len();
                    scan_mode = SC_EXP;
                end else begin
                    emit_token(lcs_pkg::K_FLOAT, held, 2'd1);
                end
            end
            SC_EXP: begin
                if (eoi) begin
                    emit_token(lcs_pkg::K_BAD, held, 2'd0);
                end else if (c == CH_PLUS || c == CH_MINUS) begin
                    grow_len();
                    scan_mode = SC_EXP_SIGN;
                end else if (dig) begin
                    grow_len();
                    scan_mode = SC_EXP_DIG;
                end else begin
                    emit_token(lcs_pkg::K_BAD, held, 2'd1);
                end
            end
            SC_EXP_SIGN: begin
                if (eoi) begin
                    emit_token(lcs_pkg::K_BAD, held, 2'd0);
                end else if (dig) begin
                    grow_len();
                    scan_mode = SC_EXP_DIG;
                end else begin
                    emit_token(lcs_pkg::K_BAD, held, 2'd1);
                end
            end
            SC_EXP_DIG: begin
                if (eoi) begin
                    emit_token(lcs_pkg::K_FLOAT, held, 2'd0);
                end else if (dig) begin
                    grow_len();
                end else begin
                    emit_token(lcs_pkg::K_FLOAT, held, 2'd1);
                end
            end
            default: begin
                clear_scan();
            end
        endcase
    endtask

    // Offer one item, wait for it to be accepted, then predict its effect.
    // Valid stays high on return so a following item can go out on the next edge.
    task automatic send_item(input logic [7:0] c, input logic eoi);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_ch           <= c;
        i_end_of_input <= eoi;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        sent_count++;
        predict_token(c, eoi);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_item(s[i], 1'b0);
        end
    endtask

    task automatic send_eoi();
        send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic send_repeated(input logic [7:0] c, input int n);
        for (int i = 0; i < n; i++) begin
            send_item(c, 1'b0);
        end
    endtask

    // Stop offering and wait until every predicted token has arrived.
    task automatic pause_until_drained();
        i_valid <= 1'b0;
        while (pending_tokens() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Receiver: check each accepted token, then pick the next ready value.
    always @(posedge i_clk) begin
        t_token tok;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_tokens() == 0) begin
                mismatch_count++;
                $display("%0t: token with none expected: kind %0d length %0d sat %0b replay %0d",
                         $time, o_kind, o_token_length, o_length_saturated, o_replay_count);
            end else begin
                tok = exp_tokens[exp_head % EXP_DEPTH];
                exp_head++;
                if (o_kind !== tok.kind || o_token_length !== tok.length ||
                    o_length_saturated !== tok.saturated || o_replay_count !== tok.replay) begin
                    mismatch_count++;
                    bad_token_count++;
                end
                if (bad_token_count <= REPORT_LIMIT) begin
                    if (o_kind !== tok.kind)
                        $display("%0t: kind expected %0d actual %0d", $time, tok.kind, o_kind);
                    if (o_token_length !== tok.length)
                        $display("%0t: token_length expected %0d actual %0d",
                                 $time, tok.length, o_token_length);
                    if (o_length_saturated !== tok.saturated)
                        $display("%0t: length_saturated expected %0b actual %0b",
                                 $time, tok.saturated, o_length_saturated);
                    if (o_replay_count !== tok.replay)
                        $display("%0t: replay_count expected %0d actual %0d",
                                 $time, tok.replay, o_replay_count);
                end
            end
        end
        i_ready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Long receiver hold-off, counted here once a test asks for it.
    always begin
        @(posedge i_clk);
        if (hold_request) begin
            rx_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            rx_hold <= 1'b0;
            while (hold_request) @(posedge i_clk);
        end
    end

    // Whitespace, both comment styles, stray characters and the byte extremes.
    task automatic test_skipping();
        send_item(CH_SPACE, 1'b0);
        send_item(CH_TAB, 1'b0);
        send_item(CH_NL, 1'b0);
        send_item(CH_VT, 1'b0);
        send_item(CH_FF, 1'b0);
        send_item(CH_CR, 1'b0);
        send_text("//a\n");
        // The star of the opener does not close the comment.
        send_text("/*/*/");
        send_text("/q#");
        send_item(8'hFF, 1'b0);
        send_item(8'h00, 1'b0);
    endtask

    task automatic test_numbers();
        send_text("12..");
        send_text("3.x");
        send_text(".5e+7 ");
        send_text(".z");
        send_text("9e;");
        send_text("4e-q");
        send_text("8E5 ");
    endtask

    task automatic test_literals();
        send_text("\"a\\\"\"");
        send_text("''");
        send_text("'\\n'");
        send_text("'b'");
    endtask

    task automatic test_operators();
        send_text("&&||&x|y");
    endtask

    // End of input in a selection of the modes that react to it, and in idle.
    task automatic test_end_of_input();
        send_text("\"ab");
        send_eoi();
        send_text("'\\");
        send_eoi();
        send_text("/*x");
        send_eoi();
        send_text("42");
        send_eoi();
        send_text("/");
        send_eoi();
        send_text("&");
        send_eoi();
        send_text(".");
        send_eoi();
        send_text("1.");
        send_eoi();
        send_text("1e");
        send_eoi();
        send_text("//z");
        send_eoi();
        send_eoi();
    endtask

    // Tokens several dozen characters long: strings, an integer and an unterminated char literal.
    task automatic test_long_tokens();
        send_item(CH_DQ, 1'b0);
        send_repeated(CH_LOW_A, LONG_LEN - 3);
        send_item(CH_DQ, 1'b0);
        send_item(CH_DQ, 1'b0);
        send_repeated(CH_LOW_A, LONG_LEN - 2);
        send_item(CH_DQ, 1'b0);
        send_repeated(CH_NINE, LONG_LEN + 5);
        send_item(CH_SPACE, 1'b0);
        send_item(CH_SQ, 1'b0);
        send_repeated(CH_LOW_A, LONG_LEN + 2);
        send_eoi();
        pause_until_drained();
    endtask

    // Receiver holds off while stray characters keep coming, so the input stalls.
    task automatic test_backpressure();
        int saved_pct;
        saved_pct   = tx_idle_pct;
        tx_idle_pct = 0;
        i_valid      <= 1'b0;
        hold_request <= 1'b1;
        @(posedge i_clk);
        @(posedge i_clk);
        send_repeated(CH_SQ + 8'd1, 24);
        hold_request <= 1'b0;
        pause_until_drained();
        tx_idle_pct = saved_pct;
    endtask

    task automatic send_digits(input int lo, input int hi);
        repeat ($urandom_range(lo, hi)) send_item(8'(CH_ZERO + $urandom_range(0, 9)), 1'b0);
    endtask

    task automatic send_exponent();
        send_item($urandom_range(0, 1) ? CH_E_LO : CH_E_UP, 1'b0);
        if ($urandom_range(0, 1))
            send_item($urandom_range(0, 1) ? CH_PLUS : CH_MINUS, 1'b0);
        send_digits(1, 3);
    endtask

    task automatic send_space();
        case ($urandom_range(0, 5))
            0: send_item(CH_SPACE, 1'b0);
            1: send_item(CH_TAB, 1'b0);
            2: send_item(CH_NL, 1'b0);
            3: send_item(CH_VT, 1'b0);
            4: send_item(CH_FF, 1'b0);
            default: send_item(CH_CR, 1'b0);
        endcase
    endtask

    // Literal body character; the quote and backslash go out as escapes.
    task automatic send_body_char(input logic [7:0] quote);
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == quote || b == CH_BSL || $urandom_range(0, 99) < 15) begin
            send_item(CH_BSL, 1'b0);
        end
        send_item(b, 1'b0);
    endtask

    // One mostly well-formed token with random content, sometimes noise.
    task automatic send_random_token();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 8) begin
            repeat ($urandom_range(1, 3)) send_space();
        end else if (sel < 14) begin
            send_text("//");
            repeat ($urandom_range(0, 6)) send_item(8'($urandom_range(0, 255)), 1'b0);
            send_item(CH_NL, 1'b0);
        end else if (sel < 20) begin
            send_text("/*");
            repeat ($urandom_range(0, 6)) begin
                send_item($urandom_range(0, 3) == 0 ? CH_STAR : 8'($urandom_range(0, 255)),
                          1'b0);
            end
            send_text("*/");
        end else if (sel < 34) begin
            send_digits(1, 6);
            if ($urandom_range(0, 3) == 0) send_text("..");
        end else if (sel < 50) begin
            case ($urandom_range(0, 3))
                0: begin send_digits(1, 4); send_item(CH_DOT, 1'b0); send_digits(1, 4); end
                1: begin send_item(CH_DOT, 1'b0); send_digits(1, 4); end
                2: begin
                    send_digits(1, 3);
                    if ($urandom_range(0, 1)) begin
                        send_item(CH_DOT, 1'b0);
                        send_digits(0, 3);
                    end
                    send_exponent();
                end
                default: begin send_digits(1, 3); send_item(CH_DOT, 1'b0); end
            endcase
        end else if (sel < 62) begin
            send_item(CH_DQ, 1'b0);
            repeat ($urandom_range(0, 6)) send_body_char(CH_DQ);
            send_item(CH_DQ, 1'b0);
        end else if (sel < 70) begin
            send_item(CH_SQ, 1'b0);
            repeat ($urandom_range(0, 2)) send_body_char(CH_SQ);
            send_item(CH_SQ, 1'b0);
        end else if (sel < 78) begin
            case ($urandom_range(0, 3))
                0: send_text("&&");
                1: send_text("||");
                2: send_item(CH_AMP, 1'b0);
                default: send_item(CH_BAR, 1'b0);
            endcase
        end else if (sel < 85) begin
            // Broken exponent or literal cut short.
            send_digits(1, 2);
            send_item($urandom_range(0, 1) ? CH_E_LO : CH_E_UP, 1'b0);
            if ($urandom_range(0, 1)) send_item(CH_MINUS, 1'b0);
            send_item(CH_SQ + 8'd1, 1'b0);
        end else if (sel < 95) begin
            repeat ($urandom_range(1, 3)) send_item(8'($urandom_range(0, 255)), 1'b0);
        end else begin
            send_eoi();
        end
        if ($urandom_range(0, 99) < 75) send_space();
    endtask

    task automatic test_random(input int tx_pct, input int rx_pct, input int n_items);
        int start;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        start = sent_count;
        while (sent_count - start < n_items) begin
            send_random_token();
        end
        pause_until_drained();
    endtask

    // Run limit.
    initial begin
        #5000000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        int waited;
        tx_idle_pct = 32;
        rx_idle_pct = 86;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_skipping();
        test_numbers();
        test_literals();
        test_operators();
        test_end_of_input();
        pause_until_drained();
        test_long_tokens();
        test_backpressure();
        test_random(32, 86, 135);
        test_random(86, 32, 135);
        test_random(0, 0, 135);

        // Drain, then keep watching the output for any stray token before the verdict.
        i_valid <= 1'b0;
        waited = 0;
        while (pending_tokens() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending_tokens() != 0) begin
            mismatch_count++;
            $display("%0t: %0d expected tokens never arrived", $time, pending_tokens());
        end
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
